[hw/rtl/pres80_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pres80_pkg: shared types, constants and layer functions
// S-box tables, bit permutations and the key register update used by the
// PRESENT-80 round unit and the key expansion logic.
// ----------------------------------------------------------------------------
package pres80_pkg;

   localparam int BLK_W     = 64;
   localparam int KEY_W     = 80;
   localparam int KLOW_W    = 16;
   localparam int NUM_RK    = 32;
   localparam int RK_AW     = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [RK_AW-1:0] LAST_STEP = 5'd31;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN
   } state_type;

   // one write into the round key memory
   typedef struct packed {
      logic             en;
      logic [RK_AW-1:0] addr;
      logic [BLK_W-1:0] data;
   } key_wr_type;

   function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'hC;
         4'h1: y = 4'h5;
         4'h2: y = 4'h6;
         4'h3: y = 4'hB;
         4'h4: y = 4'h9;
         4'h5: y = 4'h0;
         4'h6: y = 4'hA;
         4'h7: y = 4'hD;
         4'h8: y = 4'h3;
         4'h9: y = 4'hE;
         4'hA: y = 4'hF;
         4'hB: y = 4'h8;
         4'hC: y = 4'h4;
         4'hD: y = 4'h7;
         4'hE: y = 4'h1;
         default: y = 4'h2;
      endcase
      return y;
   endfunction

   function automatic logic [3:0] sbox_inv(input logic [3:0] x);
      logic [3:0] y;
      case (x)
         4'h0: y = 4'h5;
         4'h1: y = 4'hE;
         4'h2: y = 4'hF;
         4'h3: y = 4'h8;
         4'h4: y = 4'hC;
         4'h5: y = 4'h1;
         4'h6: y = 4'h2;
         4'h7: y = 4'hD;
         4'h8: y = 4'hB;
         4'h9: y = 4'h4;
         4'hA: y = 4'h6;
         4'hB: y = 4'h3;
         4'hC: y = 4'h0;
         4'hD: y = 4'h7;
         4'hE: y = 4'h9;
         default: y = 4'hA;
      endcase
      return y;
   endfunction

   function automatic logic [BLK_W-1:0] sub_fwd(input logic [BLK_W-1:0] x);
      logic [BLK_W-1:0] y;
      for (int j = 0; j < BLK_W / 4; j++) begin
         y[4*j +: 4] = sbox_fwd(x[4*j +: 4]);
      end
      return y;
   endfunction

   function automatic logic [BLK_W-1:0] sub_inv(input logic [BLK_W-1:0] x);
      logic [BLK_W-1:0] y;
      for (int j = 0; j < BLK_W / 4; j++) begin
         y[4*j +: 4] = sbox_inv(x[4*j +: 4]);
      end
      return y;
   endfunction

   // bit j moves to (16*j) mod 63, top bit stays
   function automatic logic [BLK_W-1:0] perm_fwd(input logic [BLK_W-1:0] x);
      logic [BLK_W-1:0] y;
      y = '0;
      for (int j = 0; j < BLK_W - 1; j++) begin
         y[(j * 16) % (BLK_W - 1)] = x[j];
      end
      y[BLK_W-1] = x[BLK_W-1];
      return y;
   endfunction

   // bit j moves to (4*j) mod 63, top bit stays
   function automatic logic [BLK_W-1:0] perm_inv(input logic [BLK_W-1:0] x);
      logic [BLK_W-1:0] y;
      y = '0;
      for (int j = 0; j < BLK_W - 1; j++) begin
         y[(j * 4) % (BLK_W - 1)] = x[j];
      end
      y[BLK_W-1] = x[BLK_W-1];
      return y;
   endfunction

   // rotate left 61, S-box on the top nibble, counter into bits 19..15
   function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                    input logic [RK_AW-1:0] rc);
      logic [KEY_W-1:0] n;
      n = {k[18:0], k[KEY_W-1:19]};
      n[KEY_W-1 -: 4] = sbox_fwd(n[KEY_W-1 -: 4]);
      n[19:15] = n[19:15] ^ rc;
      return n;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/present80_block_cipher.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// present80_block_cipher: PRESENT-80 encrypt / decrypt engine
// Iterative PRESENT-80 core with the round keys held in a 32 x 64 memory.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low. The result appears on
// rsp_data_out / rsp_last_out for one cycle with rsp_strobe; it cannot be
// held off. From transfer to strobe the core first spends the ST_LOAD state
// fetching the first round key, then steps the shared round unit through
// 31 rounds plus the closing key add, paced by the registered key memory read.
// A new block may be started in the cycle the strobe is shown. Busy stays
// high after reset and after every csr write while the key memory is
// refilled from the key registers; write key_high and key_low only while
// the core is idle.
// ----------------------------------------------------------------------------
module present80_block_cipher
   import pres80_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_op,
   input  wire logic [BLK_W-1:0]     req_data_in,
   input  wire logic                 req_last_in,
   output logic                      rsp_strobe,
   output logic      [BLK_W-1:0]     rsp_data_out,
   output logic                      rsp_last_out,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BLK_W-1:0]     csr_wdata
);

   logic [BLK_W-1:0]  key_high_ff;
   logic [KLOW_W-1:0] key_low_ff;
   logic              restart_ff;

   state_type         state_ff, state_in;
   logic [RK_AW-1:0]  cnt_ff, cnt_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic              op_ff, op_in;
   logic              last_ff, last_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [BLK_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [BLK_W-1:0]  key_mem [NUM_RK];
   logic [BLK_W-1:0]  rk_ff;
   logic [RK_AW-1:0]  rd_step;
   logic [RK_AW-1:0]  rd_addr;

   key_wr_type        kwr;
   logic              exp_running;
   logic [BLK_W-1:0]  round_out;
   logic              final_step;

   // key registers; refill of the key memory follows every write
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         restart_ff  <= 1'b1;
      end else begin
         restart_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               REG_KEY_HIGH: key_high_ff <= csr_wdata;
               REG_KEY_LOW:  key_low_ff  <= csr_wdata[KLOW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   pres80_keyexp u_keyexp (
      .clock   (clock),
      .reset   (reset),
      .restart (restart_ff),
      .key     ({key_high_ff, key_low_ff}),
      .wr      (kwr),
      .running (exp_running)
   );

   // decrypt walks the keys in reverse: index is step ^ 31
   assign rd_step = (state_ff == ST_LOAD) ? '0 : RK_AW'(cnt_ff + 1'b1);
   assign rd_addr = rd_step ^ {RK_AW{op_ff}};

   always_ff @(posedge clock) begin
      if (kwr.en) begin
         key_mem[kwr.addr] <= kwr.data;
      end
      rk_ff <= key_mem[rd_addr];
   end

   assign final_step = (cnt_ff == LAST_STEP);

   pres80_round u_round (
      .op         (op_ff),
      .final_step (final_step),
      .blk        (blk_ff),
      .rk         (rk_ff),
      .blk_out    (round_out)
   );

   assign busy = (state_ff != ST_IDLE) || restart_ff || exp_running;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      blk_in        = blk_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               blk_in   = req_data_in;
               op_in    = req_op;
               last_in  = req_last_in;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cnt_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            blk_in = round_out;
            cnt_in = RK_AW'(cnt_ff + 1'b1);
            if (final_step) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = round_out;
               rsp_last_in   = last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      blk_ff      <= blk_in;
      op_ff       <= op_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule
`default_nettype wire

[hw/rtl/pres80_round.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pres80_round: one cipher round
// Key add followed by S-box and permutation layers (forward for encrypt,
// inverse order and tables for decrypt); the final step is key add only.
// ----------------------------------------------------------------------------
module pres80_round
   import pres80_pkg::*;
(
   input  wire logic             op,
   input  wire logic             final_step,
   input  wire logic [BLK_W-1:0] blk,
   input  wire logic [BLK_W-1:0] rk,
   output logic      [BLK_W-1:0] blk_out
);

   logic [BLK_W-1:0] mixed;

   always_comb begin
      mixed = blk ^ rk;
      if (final_step) begin
         blk_out = mixed;
      end else if (op) begin
         blk_out = sub_inv(perm_inv(mixed));
      end else begin
         blk_out = perm_fwd(sub_fwd(mixed));
      end
   end

endmodule
`default_nettype wire

[hw/rtl/pres80_keyexp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pres80_keyexp: round key expansion
// Walks the 80-bit key register through the schedule and writes the 32
// round keys into the key memory, one per cycle, after each restart.
// ----------------------------------------------------------------------------
module pres80_keyexp
   import pres80_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              restart,
   input  wire logic [KEY_W-1:0]  key,
   output key_wr_type             wr,
   output logic                   running
);

   logic                 run_ff, run_in;
   logic [RK_AW-1:0]     cnt_ff, cnt_in;
   logic [KEY_W-1:0]     kreg_ff, kreg_in;

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      kreg_in = kreg_ff;
      wr.en   = 1'b0;
      wr.addr = cnt_ff;
      wr.data = kreg_ff[KEY_W-1 -: BLK_W];
      if (restart) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         kreg_in = key;
      end else if (run_ff) begin
         wr.en   = 1'b1;
         kreg_in = key_update(kreg_ff, RK_AW'(cnt_ff + 1'b1));
         cnt_in  = RK_AW'(cnt_ff + 1'b1);
         if (cnt_ff == LAST_STEP) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      kreg_ff <= kreg_in;
   end

   assign running = run_ff;

endmodule
`default_nettype wire

[sim/present80_block_cipher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_cipher_tb: self-checking bench for the PRESENT-80 core
// Drives encrypt and decrypt blocks through the start/busy port under several
// 80-bit keys, predicts every block with an independent cipher model and
// compares each strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module present80_block_cipher_tb
   import pres80_pkg::*;
();

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   // S-box lookups packed as 16 nibbles, entry x at bits 4x+3..4x
   localparam logic [BLK_W-1:0] SBOX_FWD = 64'h21748FE3DA09B65C;
   localparam logic [BLK_W-1:0] SBOX_INV = 64'hA970364BD21C8FE5;

   localparam int RANDOM_PHASES    = 8;
   localparam int BLOCKS_PER_PHASE = 250;
   localparam int SETTLE_CYCLES    = 40;

   typedef struct packed {
      logic [BLK_W-1:0] data;
      logic             last;
   } block_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_op = 1'b0;
   logic [BLK_W-1:0]     req_data_in = '0;
   logic                 req_last_in = 1'b0;
   logic                 rsp_strobe;
   logic [BLK_W-1:0]     rsp_data_out;
   logic                 rsp_last_out;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BLK_W-1:0]     csr_wdata = '0;

   block_result_type  pending_blocks[$];
   logic [BLK_W-1:0]  round_key[NUM_RK];
   logic [BLK_W-1:0]  key_high_shadow = '0;
   logic [KLOW_W-1:0] key_low_shadow = '0;
   logic [BLK_W-1:0]  recent_ciphertext = '0;
   int                error_count = 0;

   present80_block_cipher dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .req_last_in  (req_last_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_last_out (rsp_last_out),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // cipher model
   // ------------------------------------------------------------------------
   function automatic logic [BLK_W-1:0] substitute(input logic [BLK_W-1:0] x,
                                                   input logic [BLK_W-1:0] lut);
      logic [BLK_W-1:0] y;
      for (int n = 0; n < BLK_W / 4; n++) begin
         y[4*n +: 4] = lut[{x[4*n +: 4], 2'b00} +: 4];
      end
      return y;
   endfunction

   // bit i lands on (i * mul) mod 63; bit 63 is fixed
   function automatic logic [BLK_W-1:0] permute(input logic [BLK_W-1:0] x,
                                                input int mul);
      logic [BLK_W-1:0] y;
      y[BLK_W-1] = x[BLK_W-1];
      for (int i = 0; i < BLK_W - 1; i++) begin
         y[(i * mul) % (BLK_W - 1)] = x[i];
      end
      return y;
   endfunction

   function automatic void expand_keys();
      logic [KEY_W-1:0] k;
      logic [RK_AW-1:0] rc;
      k = {key_high_shadow, key_low_shadow};
      for (int r = 0; r < NUM_RK; r++) begin
         round_key[r] = k[KEY_W-1 -: BLK_W];
         rc = RK_AW'(r + 1);
         k = (k << 61) | (k >> 19);
         k[KEY_W-1 -: 4] = SBOX_FWD[{k[KEY_W-1 -: 4], 2'b00} +: 4];
         k[19:15] = k[19:15] ^ rc;
      end
   endfunction

   function automatic logic [BLK_W-1:0] present_cipher(input logic op,
                                                       input logic [BLK_W-1:0] blk);
      logic [BLK_W-1:0] s;
      s = blk;
      if (op == OP_ENCRYPT) begin
         for (int r = 0; r < NUM_RK - 1; r++) begin
            s = permute(substitute(s ^ round_key[r], SBOX_FWD), 16);
         end
         s = s ^ round_key[NUM_RK-1];
      end else begin
         s = s ^ round_key[NUM_RK-1];
         for (int r = NUM_RK - 2; r >= 0; r--) begin
            s = substitute(permute(s, 4), SBOX_INV) ^ round_key[r];
         end
      end
      return s;
   endfunction

   function automatic logic [BLK_W-1:0] random_block();
      logic [BLK_W-1:0] b;
      case ($urandom_range(0, 9))
         0: b = '0;
         1: b = '1;
         2: b = 64'd1 << $urandom_range(0, BLK_W - 1);
         3: b = ~(64'd1 << $urandom_range(0, BLK_W - 1));
         default: b = {$urandom, $urandom};
      endcase
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      block_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_blocks.size() == 0) begin
            $error("data_out with no block outstanding: expected none, actual %h",
                   rsp_data_out);
            error_count++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_data_out !== want.data) begin
               $error("data_out mismatch: expected %h, actual %h", want.data, rsp_data_out);
               error_count++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out mismatch: expected %b, actual %b", want.last, rsp_last_out);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // shared drivers
   // ------------------------------------------------------------------------
   // start stays high on return so back-to-back blocks need no second NBA
   task automatic push_block(input logic op, input logic [BLK_W-1:0] blk,
                             input logic last);
      block_result_type want;
      req_op      <= op;
      req_data_in <= blk;
      req_last_in <= last;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      want.data = present_cipher(op, blk);
      want.last = last;
      pending_blocks.push_back(want);
      if (op == OP_ENCRYPT) recent_ciphertext = want.data;
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // every write triggers a key memory refill, so wait it out
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [BLK_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_KEY_HIGH: key_high_shadow = value;
         REG_KEY_LOW:  key_low_shadow = value[KLOW_W-1:0];
         default: ;
      endcase
      expand_keys();
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic load_key(input logic [BLK_W-1:0] hi, input logic [BLK_W-1:0] lo);
      if ($urandom_range(0, 1) == 1) begin
         write_csr(REG_KEY_LOW, lo);
         write_csr(REG_KEY_HIGH, hi);
      end else begin
         write_csr(REG_KEY_HIGH, hi);
         write_csr(REG_KEY_LOW, lo);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // keys as left by reset
   task automatic test_zero_key();
      push_block(OP_ENCRYPT, '0, 1'b0);
      push_block(OP_ENCRYPT, '1, 1'b1);
      push_block(OP_DECRYPT, '0, 1'b0);
      push_block(OP_DECRYPT, '1, 1'b1);
      push_block(OP_ENCRYPT, 64'h0123456789ABCDEF, 1'b0);
      push_block(OP_DECRYPT, 64'hAAAAAAAAAAAAAAAA, 1'b1);
      drain();
   endtask

   task automatic test_ones_key();
      load_key('1, '1);
      push_block(OP_ENCRYPT, '0, 1'b1);
      push_block(OP_ENCRYPT, '1, 1'b0);
      push_block(OP_DECRYPT, '1, 1'b0);
      push_block(OP_DECRYPT, 64'h5555555555555555, 1'b1);
      drain();
   endtask

   // spare indexes must not disturb the key; key_low drops upper wdata bits
   task automatic test_unused_index();
      write_csr(REG_KEY_HIGH, 64'h8000000000000001);
      write_csr(REG_KEY_LOW, 64'hFFFFFFFFFFFF1234);
      write_csr(REG_SPARE_2, {$urandom, $urandom});
      write_csr(REG_SPARE_3, '1);
      push_block(OP_ENCRYPT, 64'hFEDCBA9876543210, 1'b0);
      push_block(OP_DECRYPT, 64'h8000000000000001, 1'b1);
      push_block(OP_ENCRYPT, 64'h0000000080000000, 1'b0);
      drain();
   endtask

   task automatic test_round_trip();
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      push_block(OP_ENCRYPT, 64'h1122334455667788, 1'b0);
      push_block(OP_DECRYPT, recent_ciphertext, 1'b1);
      push_block(OP_ENCRYPT, 64'hF0F0F0F00F0F0F0F, 1'b1);
      push_block(OP_DECRYPT, recent_ciphertext, 1'b0);
      drain();
   endtask

   task automatic test_random_traffic(input int n, input bit idle_allowed);
      bit               bursty;
      logic             op;
      logic [BLK_W-1:0] blk;
      bursty = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) bursty = idle_allowed && ($urandom_range(0, 1) == 1);
         if (bursty && $urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 8));
         op = ($urandom_range(0, 1) == 1) ? OP_DECRYPT : OP_ENCRYPT;
         if (op == OP_DECRYPT && $urandom_range(0, 3) == 0) blk = recent_ciphertext;
         else blk = random_block();
         push_block(op, blk, $urandom_range(0, 1) == 1);
      end
      drain();
   endtask

   task automatic test_key_sweep();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: load_key('1, '1);
            1: load_key('0, '0);
            2: load_key('0, {$urandom, $urandom});
            3: load_key('1, '0);
            default: load_key({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         // the final phase runs with start held high throughout
         test_random_traffic(BLOCKS_PER_PHASE, p != RANDOM_PHASES - 1);
      end
   endtask

   initial begin
      expand_keys();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_zero_key();
      test_ones_key();
      test_unused_index();
      test_round_trip();
      test_key_sweep();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[present80_block_cipher.f]
hw/rtl/pres80_pkg.sv
hw/rtl/pres80_round.sv
hw/rtl/pres80_keyexp.sv
hw/rtl/present80_block_cipher.sv
sim/present80_block_cipher_tb.sv
